>>> rtl/pva_pkg.sv
// Shared types and constants for the priority voice allocator.
`default_nettype none

package pva_pkg;

    localparam int NUM_SLOTS_DEF = 64;
    localparam int SLOT_W        = 6;
    localparam int PRI_W         = 8;

    localparam logic [1:0] FUNC_ACQUIRE = 2'd0;
    localparam logic [1:0] FUNC_FREE    = 2'd1;
    localparam logic [1:0] FUNC_SETPRI  = 2'd2;

    // Search record handed from cell to cell during an acquire scan
    typedef struct packed {
        logic             vld;
        logic             free_found;
        logic             pre_found;
        logic [PRI_W-1:0] pre_pri;
        logic             pre_notify;
    } scan_rec_t;

    // Broadcast write to the slot cells
    typedef struct packed {
        logic             en;
        logic             upd_busy;
        logic             busy;
        logic [PRI_W-1:0] pri;
        logic             upd_notify;
        logic             notify;
    } cell_wr_t;

endpackage

`default_nettype wire

>>> rtl/pva_cell.sv
// One slot cell: holds busy, priority and notify, and updates the passing search record.
`default_nettype none

module pva_cell
    import pva_pkg::*;
#(
    parameter int IDX_W = $clog2(NUM_SLOTS_DEF)
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [IDX_W-1:0] cell_idx,
    input  wire logic [PRI_W-1:0] req_pri,
    input  wire scan_rec_t        rec_in,
    input  wire logic [IDX_W-1:0] free_idx_in,
    input  wire logic [IDX_W-1:0] pre_idx_in,
    output scan_rec_t             rec_out,
    output logic      [IDX_W-1:0] free_idx_out,
    output logic      [IDX_W-1:0] pre_idx_out,
    input  wire cell_wr_t         wr,
    input  wire logic [IDX_W-1:0] wr_idx
);

    logic             busy_reg;
    logic [PRI_W-1:0] pri_reg;
    logic             notify_reg;
    scan_rec_t        rec_reg;
    scan_rec_t        rec_next;
    logic [IDX_W-1:0] free_idx_reg;
    logic [IDX_W-1:0] pre_idx_reg;
    logic             free_hit;
    logic             pre_hit;
    logic             wr_hit;

    assign free_hit = rec_in.vld && !rec_in.free_found && !busy_reg;
    // strictly lower than the request and strictly lower than the best so far
    assign pre_hit  = rec_in.vld && (pri_reg < req_pri) &&
                      (!rec_in.pre_found || (pri_reg < rec_in.pre_pri));
    assign wr_hit   = wr.en && (wr_idx == cell_idx);

    always_comb
    begin
        rec_next            = rec_in;
        rec_next.free_found = rec_in.free_found || free_hit;
        rec_next.pre_found  = rec_in.pre_found || pre_hit;
        if (pre_hit)
        begin
            rec_next.pre_pri    = pri_reg;
            rec_next.pre_notify = notify_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            pri_reg    <= '0;
            notify_reg <= 1'b0;
            rec_reg    <= '0;
        end
        else
        begin
            rec_reg <= rec_next;
            if (wr_hit)
            begin
                pri_reg <= wr.pri;
                if (wr.upd_busy)
                begin
                    busy_reg <= wr.busy;
                end
                if (wr.upd_notify)
                begin
                    notify_reg <= wr.notify;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        free_idx_reg <= free_hit ? cell_idx : free_idx_in;
        pre_idx_reg  <= pre_hit ? cell_idx : pre_idx_in;
    end

    assign rec_out      = rec_reg;
    assign free_idx_out = free_idx_reg;
    assign pre_idx_out  = pre_idx_reg;

endmodule

`default_nettype wire

>>> rtl/priority_voice_allocator_unit.sv
// Priority voice allocator: control, result register and the chain of slot cells.
// Acquire: a start strobe launches the search record, which
//   walks the chain of slot cells one cell per cycle; the pick is made at the end of the chain.
// Free and set-priority: go straight to the apply step, which releases the result.
// One item at a time; a finished result waits in the output register for out_ready.
// Reset (rst_n, asynchronous, active low) clears every slot: idle, priority 0, no notify.
`default_nettype none

module priority_voice_allocator_unit
    import pva_pkg::*;
#(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [1:0]        func,
    input  wire logic [SLOT_W-1:0] slot,
    input  wire logic [PRI_W-1:0]  priority_req,
    input  wire logic              wants_notify,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic                   granted,
    output logic      [SLOT_W-1:0] granted_slot,
    output logic                   evict_notice
);

    localparam int IDX_W = $clog2(NUM_SLOTS);
    localparam int CNT_W = $clog2(NUM_SLOTS + 1);
    localparam int CMP_W = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SCAN  = 3'b010,
        S_APPLY = 3'b100
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic                start_reg;
    logic [1:0]          op_func_reg;
    logic [SLOT_W-1:0]   op_slot_reg;
    logic [PRI_W-1:0]    op_pri_reg;
    logic                op_notify_reg;
    logic                found_reg;
    logic [IDX_W-1:0]    pick_idx_reg;
    logic                evict_reg;
    logic                out_valid_reg;
    logic                granted_reg;
    logic [SLOT_W-1:0]   granted_slot_reg;
    logic                evict_notice_reg;

    logic                in_fire;
    logic                apply_fire;
    logic                slot_in_range;
    logic                op_is_acq;
    cell_wr_t            wr;
    logic [IDX_W-1:0]    wr_idx;

    scan_rec_t           rec_node      [NUM_SLOTS+1];
    logic [IDX_W-1:0]    free_idx_node [NUM_SLOTS+1];
    logic [IDX_W-1:0]    pre_idx_node  [NUM_SLOTS+1];
    scan_rec_t           last_rec;

    assign in_ready      = (state_reg == S_IDLE);
    assign in_fire       = in_valid && in_ready;
    assign apply_fire    = (state_reg == S_APPLY) && (!out_valid_reg || out_ready);
    assign slot_in_range = CMP_W'(slot) < CMP_W'(NUM_SLOTS);
    assign op_is_acq     = (op_func_reg == FUNC_ACQUIRE);
    assign last_rec      = rec_node[NUM_SLOTS];

    // record entering the first cell
    always_comb
    begin
        rec_node[0]      = '0;
        rec_node[0].vld  = start_reg;
        free_idx_node[0] = '0;
        pre_idx_node[0]  = '0;
    end

    for (genvar g = 0; g < NUM_SLOTS; g++)
    begin : g_cell
        pva_cell #(
            .IDX_W (IDX_W)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .cell_idx     (IDX_W'(g)),
            .req_pri      (op_pri_reg),
            .rec_in       (rec_node[g]),
            .free_idx_in  (free_idx_node[g]),
            .pre_idx_in   (pre_idx_node[g]),
            .rec_out      (rec_node[g+1]),
            .free_idx_out (free_idx_node[g+1]),
            .pre_idx_out  (pre_idx_node[g+1]),
            .wr           (wr),
            .wr_idx       (wr_idx)
        );
    end

    // write to the chosen slot as the result is released
    always_comb
    begin
        wr        = '0;
        wr.en     = apply_fire && found_reg;
        wr.pri    = op_pri_reg;
        wr_idx    = IDX_W'(op_slot_reg);
        unique case (op_func_reg)
            FUNC_ACQUIRE:
            begin
                wr.upd_busy   = 1'b1;
                wr.busy       = 1'b1;
                wr.upd_notify = 1'b1;
                wr.notify     = op_notify_reg;
                wr_idx        = pick_idx_reg;
            end
            FUNC_FREE:
            begin
                wr.upd_busy = 1'b1;
                wr.busy     = 1'b0;
                wr.pri      = '0;
            end
            default:
            begin
                wr.upd_busy = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = (func == FUNC_ACQUIRE) ? S_SCAN : S_APPLY;
                end
            end
            S_SCAN:
            begin
                if (last_rec.vld)
                begin
                    state_next = S_APPLY;
                end
            end
            S_APPLY:
            begin
                if (apply_fire)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            start_reg <= in_fire && (func == FUNC_ACQUIRE);
            if (apply_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_func_reg   <= func;
            op_slot_reg   <= slot;
            op_pri_reg    <= priority_req;
            op_notify_reg <= wants_notify;
            found_reg     <= ((func == FUNC_FREE) || (func == FUNC_SETPRI)) && slot_in_range;
            evict_reg     <= 1'b0;
        end
        else if ((state_reg == S_SCAN) && last_rec.vld)
        begin
            // a free slot always wins over preemption
            found_reg    <= last_rec.free_found || last_rec.pre_found;
            pick_idx_reg <= last_rec.free_found ? free_idx_node[NUM_SLOTS]
                                                : pre_idx_node[NUM_SLOTS];
            evict_reg    <= !last_rec.free_found && last_rec.pre_found &&
                            last_rec.pre_notify;
        end
        if (apply_fire)
        begin
            granted_reg      <= found_reg;
            evict_notice_reg <= evict_reg;
            if (op_is_acq)
            begin
                granted_slot_reg <= found_reg ? SLOT_W'(pick_idx_reg) : '0;
            end
            else
            begin
                granted_slot_reg <= op_slot_reg;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign granted      = granted_reg;
    assign granted_slot = granted_slot_reg;
    assign evict_notice = evict_notice_reg;

    // only one item in flight
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !in_ready)
        else $error("item taken while another is in flight");

    // the search record only reaches the end of the chain during a scan
    a_scan_end: assert property (@(posedge clk) disable iff (!rst_n)
        last_rec.vld |-> (state_reg == S_SCAN))
        else $error("search record left the chain outside a scan");

    // a new result is only loaded from the apply step
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_APPLY))
        else $error("result loaded outside the apply step");

    // an eviction notice comes only with a granted acquire
    a_evict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && evict_notice_reg |-> granted_reg)
        else $error("eviction notice without grant");

endmodule

`default_nettype wire
